@@ rtl/core/kst_pkg.sv @@
// ----------------------------------------------------------------------------
// kst_pkg: shared types and helpers of the keyframe spline table
// Payload structs, command and status codes, and the component helpers
// used by the spline sequencer.
// ----------------------------------------------------------------------------
`default_nettype none
package kst_pkg;

    localparam int MAX_KEYS_DEF = 64;
    localparam int ACC_W        = 42;   // spline accumulator width
    localparam int U_W          = 16;   // fraction width
    localparam int LAST_COMP    = 9;    // pos 0-2, pos+up 3-5, look 6-8, aperture 9

    localparam logic [31:0] TOTAL_RESET = 32'h0001_0000;

    localparam logic [1:0] CMD_ADD    = 2'd0;
    localparam logic [1:0] CMD_CHANGE = 2'd1;
    localparam logic [1:0] CMD_DELETE = 2'd2;
    localparam logic [1:0] CMD_QUERY  = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_DUP   = 2'd1;
    localparam logic [1:0] ST_NOKEY = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    typedef struct packed {
        logic [1:0]         command;
        logic [31:0]        key_time;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] look_x;
        logic signed [31:0] look_y;
        logic signed [31:0] look_z;
        logic signed [31:0] up_x;
        logic signed [31:0] up_y;
        logic signed [31:0] up_z;
        logic [23:0]        aperture;
    } t_in;

    typedef struct packed {
        logic [1:0]         status;
        logic [31:0]        out_time;
        logic signed [31:0] out_pos_x;
        logic signed [31:0] out_pos_y;
        logic signed [31:0] out_pos_z;
        logic signed [31:0] out_look_x;
        logic signed [31:0] out_look_y;
        logic signed [31:0] out_look_z;
        logic signed [31:0] out_up_x;
        logic signed [31:0] out_up_y;
        logic signed [31:0] out_up_z;
        logic signed [31:0] out_aperture;
    } t_out;

    typedef struct packed {
        logic [31:0]        key_time;
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
        logic signed [31:0] look_x;
        logic signed [31:0] look_y;
        logic signed [31:0] look_z;
        logic signed [31:0] up_x;
        logic signed [31:0] up_y;
        logic signed [31:0] up_z;
        logic [23:0]        aperture;
    } t_key;

    localparam int KEY_W = $bits(t_key);

    // one spline component of a key, widened to 33 signed bits
    function automatic logic signed [32:0] key_elem(t_key k, logic [3:0] j);
        logic signed [32:0] v;
        v = '0;
        case (j)
            4'd0: v = 33'(k.pos_x);
            4'd1: v = 33'(k.pos_y);
            4'd2: v = 33'(k.pos_z);
            4'd3: v = 33'(k.pos_x) + 33'(k.up_x);
            4'd4: v = 33'(k.pos_y) + 33'(k.up_y);
            4'd5: v = 33'(k.pos_z) + 33'(k.up_z);
            4'd6: v = 33'(k.look_x);
            4'd7: v = 33'(k.look_y);
            4'd8: v = 33'(k.look_z);
            default: v = $signed({9'd0, k.aperture});
        endcase
        return v;
    endfunction

    // saturate to 32 signed bits
    function automatic logic signed [31:0] sat32(logic signed [ACC_W-1:0] x);
        logic signed [31:0] r;
        if (x > $signed(ACC_W'(32'sh7FFF_FFFF))) begin
            r = 32'sh7FFF_FFFF;
        end else if (x < -$signed(ACC_W'(33'sh0_8000_0000))) begin
            r = 32'sh8000_0000;
        end else begin
            r = x[31:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

@@ rtl/core/kst_ram.sv @@
// ----------------------------------------------------------------------------
// kst_ram: generic simple dual-port RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none
module kst_ram #(
    parameter int W = 8,
    parameter int D = 16
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_we,
    input  wire logic [$clog2(D)-1:0] i_waddr,
    input  wire logic [W-1:0]         i_wdata,
    input  wire logic [$clog2(D)-1:0] i_raddr,
    output logic      [W-1:0]         o_rdata
);
    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

@@ rtl/core/kst_div.sv @@
// ----------------------------------------------------------------------------
// kst_div: iterative fraction divider
// Computes floor((num << 16) / den) for num < den, one quotient bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module kst_div (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     i_start,
    input  wire logic [31:0]              i_num,
    input  wire logic [31:0]              i_den,
    output logic                          o_done,
    output logic [kst_pkg::U_W-1:0]       o_quot
);
    localparam int CNT_W = $clog2(kst_pkg::U_W + 1);

    logic [32:0]              r_rem;
    logic [31:0]              r_den;
    logic [kst_pkg::U_W-1:0]  r_quot;
    logic [CNT_W-1:0]         r_cnt;
    logic                     r_busy;
    logic                     r_done;
    logic [32:0]              rem2;
    logic                     ge;

    assign rem2 = {r_rem[31:0], 1'b0};
    assign ge   = rem2 >= {1'b0, r_den};

    // restoring divide loop
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_rem  <= {1'b0, i_num};
                r_den  <= i_den;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem  <= ge ? (rem2 - {1'b0, r_den}) : rem2;
                r_quot <= {r_quot[kst_pkg::U_W-2:0], ge};
                r_cnt  <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(kst_pkg::U_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_quot;
endmodule
`default_nettype wire

@@ rtl/core/kst_mac.sv @@
// ----------------------------------------------------------------------------
// kst_mac: shared spline multiplier
// Registered product of the signed accumulator and the unsigned fraction.
// ----------------------------------------------------------------------------
`default_nettype none
module kst_mac (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_en,
    input  wire logic signed [kst_pkg::ACC_W-1:0]       i_a,
    input  wire logic [kst_pkg::U_W-1:0]                i_u,
    output logic signed [kst_pkg::ACC_W+kst_pkg::U_W:0] o_prod
);
    logic signed [kst_pkg::ACC_W+kst_pkg::U_W:0] r_prod;

    // multiply with a register behind it
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod <= i_a * $signed({1'b0, i_u});
        end
    end

    assign o_prod = r_prod;
endmodule
`default_nettype wire

@@ rtl/core/keyframe_spline_table_unit.sv @@
// ----------------------------------------------------------------------------
// keyframe_spline_table_unit: sorted camera keyframe table with spline query
// Add, change, delete and query of keyframes held in one RAM.
// ----------------------------------------------------------------------------
// Usage:
// An item is one transfer on the input channel (i_in_valid / o_in_ready);
// every item gives exactly one result transfer (o_out_valid / i_out_ready).
// i_cfg_we writes total_time, the upper clamp of query times.
// One item at a time: o_in_ready is high only while the sequencer is idle.
// A linear scan of the table reads one key at a time up to the first key at
// or after the item time. Add shifts keys up, delete shifts them down, with
// one read and one write per moved key. A query between keys loads four keys,
// runs the fraction divider and then computes 10 spline components on the
// shared multiplier, one after the other.
// A finished result sits in the output register; the next item is taken
// while it waits, and its own result waits until the receiver takes it.
// Reset clears the key count and sets total_time to 32'h0001_0000; RAM
// contents need no clearing since only entries below the count are read.
// ----------------------------------------------------------------------------
`default_nettype none
module keyframe_spline_table_unit #(
    parameter int MAX_KEYS = kst_pkg::MAX_KEYS_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_in_valid,
    output logic               o_in_ready,
    input  wire kst_pkg::t_in  i_in_data,
    output logic               o_out_valid,
    input  wire logic          i_out_ready,
    output kst_pkg::t_out      o_out_data,
    input  wire logic          i_cfg_we,
    input  wire logic [31:0]   i_cfg_wdata
);
    localparam int AW = $clog2(MAX_KEYS);
    localparam int CW = $clog2(MAX_KEYS + 1);
    localparam int AC = kst_pkg::ACC_W;
    localparam int PW = kst_pkg::ACC_W + kst_pkg::U_W + 1;

    localparam logic [4:0] S_IDLE     = 5'd0;
    localparam logic [4:0] S_SCAN_RD  = 5'd1;
    localparam logic [4:0] S_SCAN_CHK = 5'd2;
    localparam logic [4:0] S_DECIDE   = 5'd3;
    localparam logic [4:0] S_SHIFT_RD = 5'd4;
    localparam logic [4:0] S_SHIFT_WR = 5'd5;
    localparam logic [4:0] S_WRITE    = 5'd6;
    localparam logic [4:0] S_DEL_RD   = 5'd7;
    localparam logic [4:0] S_DEL_WR   = 5'd8;
    localparam logic [4:0] S_EMIT_RD  = 5'd9;
    localparam logic [4:0] S_EMIT_CHK = 5'd10;
    localparam logic [4:0] S_LD_RD    = 5'd11;
    localparam logic [4:0] S_LD_CHK   = 5'd12;
    localparam logic [4:0] S_DIV      = 5'd13;
    localparam logic [4:0] S_DIV_WAIT = 5'd14;
    localparam logic [4:0] S_COEF     = 5'd15;
    localparam logic [4:0] S_MUL      = 5'd16;
    localparam logic [4:0] S_ACC      = 5'd17;
    localparam logic [4:0] S_FIN      = 5'd18;
    localparam logic [4:0] S_OUT      = 5'd19;

    logic [4:0]                r_state;
    kst_pkg::t_in              r_item;
    logic [31:0]               r_t;
    logic [31:0]               r_total;
    logic [CW-1:0]             r_cnt;
    logic [CW-1:0]             r_idx;
    logic [CW-1:0]             r_pos;
    logic                      r_hit;
    logic [1:0]                r_slot;
    kst_pkg::t_key             r_k [4];
    logic [kst_pkg::U_W-1:0]   r_u;
    logic [3:0]                r_j;
    logic [1:0]                r_step;
    logic signed [AC-1:0]      r_acc;
    logic signed [AC-1:0]      r_c2;
    logic signed [AC-1:0]      r_c1;
    logic signed [AC-1:0]      r_c0;
    logic signed [AC-1:0]      r_pk [3];
    kst_pkg::t_out             r_res;
    kst_pkg::t_out             r_out;
    logic                      r_out_valid;

    logic                      ram_we;
    logic [CW-1:0]             ram_waddr;
    logic [kst_pkg::KEY_W-1:0] ram_wdata;
    logic [CW-1:0]             ram_raddr;
    logic [kst_pkg::KEY_W-1:0] ram_rdata;
    kst_pkg::t_key             q_key;
    kst_pkg::t_key             item_key;
    logic [CW-1:0]             ld_addr;
    logic                      div_start;
    logic                      div_done;
    logic [kst_pkg::U_W-1:0]   div_quot;
    logic                      mac_en;
    logic signed [PW-1:0]      mac_prod;
    logic signed [PW-1:0]      prod_sh;
    logic signed [AC-1:0]      addend;
    logic signed [AC-1:0]      half;
    logic signed [AC-1:0]      p0, p1, p2, p3;
    logic [31:0]               in_t;
    kst_pkg::t_out             res_init;
    logic                      out_load;

    assign q_key = kst_pkg::t_key'(ram_rdata);
    assign item_key = '{key_time: r_item.key_time,
                        pos_x: r_item.pos_x, pos_y: r_item.pos_y, pos_z: r_item.pos_z,
                        look_x: r_item.look_x, look_y: r_item.look_y,
                        look_z: r_item.look_z,
                        up_x: r_item.up_x, up_y: r_item.up_y, up_z: r_item.up_z,
                        aperture: r_item.aperture};

    // item time, clamped for queries
    assign in_t = (i_in_data.command == kst_pkg::CMD_QUERY &&
                   i_in_data.key_time > r_total) ? r_total : i_in_data.key_time;

    // starting result: ok status, item time, zero camera
    always_comb begin
        res_init          = '0;
        res_init.status   = kst_pkg::ST_OK;
        res_init.out_time = in_t;
    end

    // result register loads when free or drained in the same cycle
    assign out_load = (r_state == S_OUT) && (!r_out_valid || i_out_ready);

    // address of the key loaded into each spline slot, clamped at the ends
    always_comb begin
        case (r_slot)
            2'd0:    ld_addr = (r_pos >= CW'(2)) ? r_pos - CW'(2) : '0;
            2'd1:    ld_addr = r_pos - CW'(1);
            2'd2:    ld_addr = r_pos;
            default: ld_addr = (r_pos + CW'(1) < r_cnt) ? r_pos + CW'(1) : r_cnt - CW'(1);
        endcase
    end

    // table port control
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_idx;
        ram_wdata = ram_rdata;
        ram_raddr = r_idx;
        unique case (r_state)
            S_SHIFT_RD: ram_raddr = r_idx - CW'(1);
            S_DEL_RD:   ram_raddr = r_idx + CW'(1);
            S_LD_RD:    ram_raddr = ld_addr;
            S_SHIFT_WR,
            S_DEL_WR:   ram_we = 1'b1;
            S_WRITE: begin
                ram_we    = 1'b1;
                ram_waddr = r_pos;
                ram_wdata = item_key;
            end
            default: ;
        endcase
    end

    kst_ram #(.W(kst_pkg::KEY_W), .D(MAX_KEYS)) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr[AW-1:0]),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr[AW-1:0]),
        .o_rdata (ram_rdata)
    );

    assign div_start = (r_state == S_DIV);

    kst_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_t - r_k[1].key_time),
        .i_den   (r_k[2].key_time - r_k[1].key_time),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    assign mac_en = (r_state == S_MUL);

    kst_mac u_mac (
        .i_clk  (i_clk),
        .i_en   (mac_en),
        .i_a    (r_acc),
        .i_u    (r_u),
        .o_prod (mac_prod)
    );

    // spline operands and step arithmetic
    assign p0      = AC'(kst_pkg::key_elem(r_k[0], r_j));
    assign p1      = AC'(kst_pkg::key_elem(r_k[1], r_j));
    assign p2      = AC'(kst_pkg::key_elem(r_k[2], r_j));
    assign p3      = AC'(kst_pkg::key_elem(r_k[3], r_j));
    assign prod_sh = mac_prod >>> kst_pkg::U_W;
    assign addend  = (r_step == 2'd0) ? r_c2 : ((r_step == 2'd1) ? r_c1 : r_c0);
    assign half    = r_acc >>> 1;

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_total     <= kst_pkg::TOTAL_RESET;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_total <= i_cfg_wdata;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_item  <= i_in_data;
                        r_t     <= in_t;
                        r_res   <= res_init;
                        r_idx   <= '0;
                        r_hit   <= 1'b0;
                        r_pos   <= r_cnt;
                        r_state <= (r_cnt == '0) ? S_DECIDE : S_SCAN_RD;
                    end
                end
                S_SCAN_RD: r_state <= S_SCAN_CHK;
                S_SCAN_CHK: begin
                    if (q_key.key_time == r_t) begin
                        r_hit   <= 1'b1;
                        r_pos   <= r_idx;
                        r_state <= S_DECIDE;
                    end else if (q_key.key_time > r_t) begin
                        r_pos   <= r_idx;
                        r_state <= S_DECIDE;
                    end else begin
                        r_idx   <= r_idx + CW'(1);
                        r_state <= (r_idx + CW'(1) == r_cnt) ? S_DECIDE : S_SCAN_RD;
                    end
                end
                S_DECIDE: begin
                    unique case (r_item.command)
                        kst_pkg::CMD_ADD: begin
                            if (r_hit) begin
                                r_res.status <= kst_pkg::ST_DUP;
                                r_state      <= S_OUT;
                            end else if (r_cnt == CW'(MAX_KEYS)) begin
                                r_res.status <= kst_pkg::ST_FULL;
                                r_state      <= S_OUT;
                            end else begin
                                r_idx   <= r_cnt;
                                r_state <= (r_cnt > r_pos) ? S_SHIFT_RD : S_WRITE;
                            end
                        end
                        kst_pkg::CMD_CHANGE: begin
                            if (!r_hit) begin
                                r_res.status <= kst_pkg::ST_NOKEY;
                                r_state      <= S_OUT;
                            end else begin
                                r_state <= S_WRITE;
                            end
                        end
                        kst_pkg::CMD_DELETE: begin
                            if (!r_hit) begin
                                r_res.status <= kst_pkg::ST_NOKEY;
                                r_state      <= S_OUT;
                            end else begin
                                r_idx <= r_pos;
                                if (r_pos + CW'(1) < r_cnt) begin
                                    r_state <= S_DEL_RD;
                                end else begin
                                    r_cnt   <= r_cnt - CW'(1);
                                    r_state <= S_OUT;
                                end
                            end
                        end
                        default: begin
                            if (r_hit) begin
                                r_idx   <= r_pos;
                                r_state <= S_EMIT_RD;
                            end else if (r_cnt == '0) begin
                                r_res.out_pos_x    <= r_item.pos_x;
                                r_res.out_pos_y    <= r_item.pos_y;
                                r_res.out_pos_z    <= r_item.pos_z;
                                r_res.out_look_x   <= r_item.look_x;
                                r_res.out_look_y   <= r_item.look_y;
                                r_res.out_look_z   <= r_item.look_z;
                                r_res.out_up_x     <= r_item.up_x;
                                r_res.out_up_y     <= r_item.up_y;
                                r_res.out_up_z     <= r_item.up_z;
                                r_res.out_aperture <= $signed({8'd0, r_item.aperture});
                                r_state            <= S_OUT;
                            end else if (r_pos == '0) begin
                                r_idx   <= '0;
                                r_state <= S_EMIT_RD;
                            end else if (r_pos == r_cnt) begin
                                r_idx   <= r_cnt - CW'(1);
                                r_state <= S_EMIT_RD;
                            end else begin
                                r_slot  <= 2'd0;
                                r_state <= S_LD_RD;
                            end
                        end
                    endcase
                end
                // insert: move keys up one place
                S_SHIFT_RD: r_state <= S_SHIFT_WR;
                S_SHIFT_WR: begin
                    r_idx   <= r_idx - CW'(1);
                    r_state <= (r_idx - CW'(1) == r_pos) ? S_WRITE : S_SHIFT_RD;
                end
                S_WRITE: begin
                    if (r_item.command == kst_pkg::CMD_ADD) begin
                        r_cnt <= r_cnt + CW'(1);
                    end
                    r_state <= S_OUT;
                end
                // delete: move keys down one place
                S_DEL_RD: r_state <= S_DEL_WR;
                S_DEL_WR: begin
                    r_idx <= r_idx + CW'(1);
                    if (r_idx + CW'(2) < r_cnt) begin
                        r_state <= S_DEL_RD;
                    end else begin
                        r_cnt   <= r_cnt - CW'(1);
                        r_state <= S_OUT;
                    end
                end
                S_EMIT_RD: r_state <= S_EMIT_CHK;
                S_EMIT_CHK: begin
                    r_res.out_pos_x    <= q_key.pos_x;
                    r_res.out_pos_y    <= q_key.pos_y;
                    r_res.out_pos_z    <= q_key.pos_z;
                    r_res.out_look_x   <= q_key.look_x;
                    r_res.out_look_y   <= q_key.look_y;
                    r_res.out_look_z   <= q_key.look_z;
                    r_res.out_up_x     <= q_key.up_x;
                    r_res.out_up_y     <= q_key.up_y;
                    r_res.out_up_z     <= q_key.up_z;
                    r_res.out_aperture <= $signed({8'd0, q_key.aperture});
                    r_state            <= S_OUT;
                end
                // load the four spline keys
                S_LD_RD: r_state <= S_LD_CHK;
                S_LD_CHK: begin
                    r_k[r_slot] <= q_key;
                    r_slot      <= r_slot + 2'd1;
                    r_state     <= (r_slot == 2'd3) ? S_DIV : S_LD_RD;
                end
                S_DIV: r_state <= S_DIV_WAIT;
                S_DIV_WAIT: begin
                    if (div_done) begin
                        r_u     <= div_quot;
                        r_j     <= '0;
                        r_state <= S_COEF;
                    end
                end
                // cubic coefficients of one component
                S_COEF: begin
                    r_acc   <= (p3 - p0) + (p1 - p2) + ((p1 - p2) <<< 1);
                    r_c2    <= (p0 <<< 1) - (p1 <<< 2) - p1 + (p2 <<< 2) - p3;
                    r_c1    <= p2 - p0;
                    r_c0    <= p1 <<< 1;
                    r_step  <= 2'd0;
                    r_state <= S_MUL;
                end
                S_MUL: r_state <= S_ACC;
                S_ACC: begin
                    r_acc <= prod_sh[AC-1:0] + addend;
                    if (r_step == 2'd2) begin
                        r_state <= S_FIN;
                    end else begin
                        r_step  <= r_step + 2'd1;
                        r_state <= S_MUL;
                    end
                end
                S_FIN: begin
                    case (r_j)
                        4'd0: begin r_pk[0] <= half; r_res.out_pos_x <= kst_pkg::sat32(half); end
                        4'd1: begin r_pk[1] <= half; r_res.out_pos_y <= kst_pkg::sat32(half); end
                        4'd2: begin r_pk[2] <= half; r_res.out_pos_z <= kst_pkg::sat32(half); end
                        4'd3: r_res.out_up_x <= kst_pkg::sat32(half - r_pk[0]);
                        4'd4: r_res.out_up_y <= kst_pkg::sat32(half - r_pk[1]);
                        4'd5: r_res.out_up_z <= kst_pkg::sat32(half - r_pk[2]);
                        4'd6: r_res.out_look_x <= kst_pkg::sat32(half);
                        4'd7: r_res.out_look_y <= kst_pkg::sat32(half);
                        4'd8: r_res.out_look_z <= kst_pkg::sat32(half);
                        default: r_res.out_aperture <= kst_pkg::sat32(half);
                    endcase
                    if (r_j == 4'(kst_pkg::LAST_COMP)) begin
                        r_state <= S_OUT;
                    end else begin
                        r_j     <= r_j + 4'd1;
                        r_state <= S_COEF;
                    end
                end
                S_OUT: begin
                    if (out_load) begin
                        r_out   <= r_res;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // key count never passes the table size
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(MAX_KEYS))
        else $error("key count above table size");

    // one item at a time
    a_busy_after_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("ready right after an input transfer");

    // divider finishes only while the sequencer waits for it
    a_div_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DIV_WAIT))
        else $error("divider done outside its wait state");

endmodule
`default_nettype wire
